[hw/rtl/uvg_pkg.sv]
// ----------------------------------------------------------------------------
// uvg_pkg
// shared widths, codes and result types of the two-cell undervoltage guard
// ----------------------------------------------------------------------------
package uvg_pkg;

    localparam int ADC_W      = 10;
    localparam int LIMIT_W    = 14;
    localparam int DELAY_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FULL_W     = 14;
    localparam int DIV_W      = 24;
    localparam int DIV_STEPS  = DIV_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int MV_W       = 16;
    localparam int MV2_W      = 17;
    localparam int DIFF_W     = DIV_W + 1;

    localparam logic [FULL_W-1:0]  CELL1_FULL_MV   = FULL_W'(4200);
    localparam logic [FULL_W-1:0]  PACK_FULL_MV    = FULL_W'(8400);
    localparam logic [DELAY_W-1:0] FLASH_PERIOD_MS = DELAY_W'(1600);
    localparam logic [DELAY_W-1:0] ELAPSED_MAX     = {DELAY_W{1'b1}};
    localparam logic [MV_W-1:0]    MV_SAT          = {MV_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_MAIN  = 2'd0,
        MODE_STORE = 2'd1,
        MODE_CALIB = 2'd2,
        MODE_UNDER = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UV_LIMIT  = 2'd0,
        REG_UV_DELAY  = 2'd1,
        REG_CAL_CELL1 = 2'd2,
        REG_CAL_PACK  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [MV_W-1:0]         cell1_mv;
        logic signed [MV2_W-1:0] cell2_mv;
        logic                    low;
    } merge_t;

endpackage

[hw/rtl/uvg_if.sv]
// ----------------------------------------------------------------------------
// uvg channel interfaces
// valid/ready channels for sample words, result words and register writes
// ----------------------------------------------------------------------------
interface uvg_in_if
    import uvg_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [ADC_W-1:0] adc_cell1;
    logic [ADC_W-1:0] adc_pack;
    logic             calibrate_request;

    modport source (output valid, kind, adc_cell1, adc_pack, calibrate_request,
                    input ready);
    modport sink   (input valid, kind, adc_cell1, adc_pack, calibrate_request,
                    output ready);
endinterface

interface uvg_out_if
    import uvg_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [MV_W-1:0]         cell1_mv;
    logic signed [MV2_W-1:0] cell2_mv;
    logic                    store_request;
    logic                    flash_request;
    logic [ADC_W-1:0]        calib_cell1;
    logic [ADC_W-1:0]        calib_pack;

    modport source (output valid, mode, cell1_mv, cell2_mv, store_request,
                    flash_request, calib_cell1, calib_pack, input ready);
    modport sink   (input valid, mode, cell1_mv, cell2_mv, store_request,
                    flash_request, calib_cell1, calib_pack, output ready);
endinterface

interface uvg_cfg_if
    import uvg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[hw/rtl/uvg_div_lane.sv]
// ----------------------------------------------------------------------------
// uvg_div_lane
// one scaling lane: raw*full, then a restoring divide by the calibration,
// one quotient bit per cycle; a zero calibration reads as 0 mV
// ----------------------------------------------------------------------------
module uvg_div_lane
    import uvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADC_W-1:0]  raw,
    input  logic [FULL_W-1:0] full,
    input  logic [ADC_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    quo_next;
    logic [ADC_W-1:0]    rem_reg;
    logic [ADC_W-1:0]    rem_next;
    logic [ADC_W:0]      rem_sh;
    logic [ADC_W:0]      rem_diff;
    logic [DIV_W-1:0]    product;

    assign product  = DIV_W'(raw) * DIV_W'(full);
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor};

    always_comb
    begin
        if (rem_sh >= {1'b0, divisor})
        begin
            rem_next = rem_diff[ADC_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[ADC_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= product;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (divisor == '0) ? '0 : quo_reg;

endmodule

[hw/rtl/uvg_merge.sv]
// ----------------------------------------------------------------------------
// uvg_merge
// combines the two lane quotients: cell 2, saturation and the low-cell flag
// ----------------------------------------------------------------------------
module uvg_merge
    import uvg_pkg::*;
(
    input  logic [DIV_W-1:0]   cell1_q,
    input  logic [DIV_W-1:0]   pack_q,
    input  logic [LIMIT_W-1:0] limit_mv,
    output merge_t             merged
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] limit_s;
    logic signed [DIFF_W-1:0] pos_sat;
    logic signed [DIFF_W-1:0] neg_sat;

    assign diff    = $signed({1'b0, pack_q}) - $signed({1'b0, cell1_q});
    assign limit_s = $signed(DIFF_W'(limit_mv));
    assign pos_sat = $signed(DIFF_W'(MV_SAT));
    assign neg_sat = -pos_sat;

    always_comb
    begin
        merged.low = (cell1_q < DIV_W'(limit_mv)) || (diff < limit_s);

        if (cell1_q > DIV_W'(MV_SAT))
            merged.cell1_mv = MV_SAT;
        else
            merged.cell1_mv = cell1_q[MV_W-1:0];

        if (diff > pos_sat)
            merged.cell2_mv = pos_sat[MV2_W-1:0];
        else if (diff < neg_sat)
            merged.cell2_mv = neg_sat[MV2_W-1:0];
        else
            merged.cell2_mv = diff[MV2_W-1:0];
    end

endmodule

[hw/rtl/two_cell_undervoltage_guard.sv]
// ----------------------------------------------------------------------------
// two_cell_undervoltage_guard
// scales cell and pack readings, tracks low-cell time, latches undervoltage,
// runs the calibrate/store sequence and asks for periodic led flashes
// ----------------------------------------------------------------------------
// sequence: a tick or non-scaling step goes from idle to done and is committed;
// a main-mode control step first waits in calc for the 24-step divide lanes
// one word in flight: a new sample is taken only in idle, after the last commit
// reset: main mode, limit 3300 mv, delay 3000 ms, calibration 1023, timer 0
module two_cell_undervoltage_guard
    import uvg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    uvg_in_if.sink   sample,
    uvg_out_if.source result,
    uvg_cfg_if.sink  cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    logic                 kind_reg;
    logic [ADC_W-1:0]     adc1_reg;
    logic [ADC_W-1:0]     adcp_reg;
    logic                 calreq_reg;

    mode_t                mode_reg;
    mode_t                mode_next;
    mode_t                mode_eff;
    logic [ADC_W-1:0]     cal1_reg;
    logic [ADC_W-1:0]     cal1_next;
    logic [ADC_W-1:0]     calp_reg;
    logic [ADC_W-1:0]     calp_next;
    logic [DELAY_W-1:0]   elapsed_reg;
    logic [DELAY_W-1:0]   elapsed_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [DELAY_W-1:0]   delay_reg;

    logic                 out_valid_reg;
    logic [MV_W-1:0]      out_c1_next;
    logic signed [MV2_W-1:0] out_c2_next;
    logic                 out_store_next;
    logic                 out_flash_next;
    logic [MV_W-1:0]      out_c1_reg;
    logic signed [MV2_W-1:0] out_c2_reg;
    logic                 out_store_reg;
    logic                 out_flash_reg;

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 need_div;
    logic                 start;
    logic                 commit;
    logic                 done1;
    logic                 donep;
    logic [DIV_W-1:0]     q1;
    logic [DIV_W-1:0]     qp;
    merge_t               merged;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign in_fire      = sample.valid && sample.ready;
    assign cfg_fire     = cfg.valid && cfg.ready;
    assign need_div     = !sample.kind && !sample.calibrate_request && (mode_reg == MODE_MAIN);
    assign start        = in_fire && need_div;
    assign commit       = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    uvg_div_lane u_lane_cell1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .raw      (sample.adc_cell1),
        .full     (CELL1_FULL_MV),
        .divisor  (cal1_reg),
        .done     (done1),
        .quotient (q1)
    );

    uvg_div_lane u_lane_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .raw      (sample.adc_pack),
        .full     (PACK_FULL_MV),
        .divisor  (calp_reg),
        .done     (donep),
        .quotient (qp)
    );

    uvg_merge u_merge (
        .cell1_q  (q1),
        .pack_q   (qp),
        .limit_mv (limit_reg),
        .merged   (merged)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = need_div ? ST_CALC : ST_DONE;
            end
            ST_CALC:
            begin
                if (done1 && donep)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // item step: mode, calibration, timer and result fields
    always_comb
    begin
        mode_eff       = calreq_reg ? MODE_CALIB : mode_reg;
        mode_next      = mode_reg;
        cal1_next      = cal1_reg;
        calp_next      = calp_reg;
        elapsed_next   = elapsed_reg;
        out_c1_next    = '0;
        out_c2_next    = '0;
        out_store_next = 1'b0;
        out_flash_next = 1'b0;
        if (kind_reg)
        begin
            if (elapsed_reg != ELAPSED_MAX)
                elapsed_next = elapsed_reg + 1'b1;
        end
        else
        begin
            mode_next = mode_eff;
            case (mode_eff)
                MODE_MAIN:
                begin
                    if (merged.low)
                    begin
                        if (elapsed_reg >= delay_reg)
                        begin
                            mode_next    = MODE_UNDER;
                            elapsed_next = '0;
                        end
                    end
                    else
                    begin
                        elapsed_next = '0;
                    end
                    out_c1_next = merged.cell1_mv;
                    out_c2_next = merged.cell2_mv;
                end
                MODE_STORE:
                begin
                    out_store_next = 1'b1;
                    mode_next      = MODE_MAIN;
                end
                MODE_CALIB:
                begin
                    cal1_next = adc1_reg;
                    calp_next = adcp_reg;
                    mode_next = MODE_STORE;
                end
                MODE_UNDER:
                begin
                    if (elapsed_reg >= FLASH_PERIOD_MS)
                    begin
                        elapsed_next   = '0;
                        out_flash_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_MAIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MAIN;
            elapsed_reg   <= '0;
            cal1_reg      <= ADC_W'(1023);
            calp_reg      <= ADC_W'(1023);
            limit_reg     <= LIMIT_W'(3300);
            delay_reg     <= DELAY_W'(3000);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                mode_reg    <= mode_next;
                elapsed_reg <= elapsed_next;
            end
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg.addr))
                    REG_UV_LIMIT:  limit_reg <= cfg.data[LIMIT_W-1:0];
                    REG_UV_DELAY:  delay_reg <= cfg.data[DELAY_W-1:0];
                    REG_CAL_CELL1: cal1_reg  <= cfg.data[ADC_W-1:0];
                    REG_CAL_PACK:  calp_reg  <= cfg.data[ADC_W-1:0];
                    default:       limit_reg <= limit_reg;
                endcase
            end
            else if (commit)
            begin
                cal1_reg <= cal1_next;
                calp_reg <= calp_next;
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= sample.kind;
            adc1_reg   <= sample.adc_cell1;
            adcp_reg   <= sample.adc_pack;
            calreq_reg <= sample.calibrate_request;
        end
        if (commit)
        begin
            out_c1_reg    <= out_c1_next;
            out_c2_reg    <= out_c2_next;
            out_store_reg <= out_store_next;
            out_flash_reg <= out_flash_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.mode          = mode_reg;
    assign result.cell1_mv      = out_c1_reg;
    assign result.cell2_mv      = out_c2_reg;
    assign result.store_request = out_store_reg;
    assign result.flash_request = out_flash_reg;
    assign result.calib_cell1   = cal1_reg;
    assign result.calib_pack    = calp_reg;

endmodule

[hw/rtl/uvg_checker.sv]
// ----------------------------------------------------------------------------
// uvg_checker
// port-level checks of the undervoltage guard, bound to the top level
// ----------------------------------------------------------------------------
module uvg_checker
    import uvg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [1:0]              mode,
    input logic [MV_W-1:0]         cell1_mv,
    input logic signed [MV2_W-1:0] cell2_mv,
    input logic                    store_request,
    input logic                    flash_request
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell1_mv) && $stable(cell2_mv)
            && $stable(store_request) && $stable(flash_request))
        else $error("result word changed while stalled");

    // one word in flight: no back-to-back accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while previous word busy");

    a_store_main: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_request |-> mode == MODE_MAIN)
        else $error("store request outside main mode");

    a_flash_under: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flash_request |-> mode == MODE_UNDER && !store_request)
        else $error("flash request outside undervoltage mode");

    a_volt_main: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cell1_mv != '0 || cell2_mv != '0) |->
            mode == MODE_MAIN || mode == MODE_UNDER)
        else $error("voltage reported in store or calibrate mode");

endmodule

bind two_cell_undervoltage_guard uvg_checker u_uvg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .mode          (result.mode),
    .cell1_mv      (result.cell1_mv),
    .cell2_mv      (result.cell2_mv),
    .store_request (result.store_request),
    .flash_request (result.flash_request)
);

[verif/two_cell_undervoltage_guard_tb.sv]
// ----------------------------------------------------------------------------
// two_cell_undervoltage_guard_tb
// Self-checking bench for the two-cell undervoltage guard. An in-bench
// predictor follows every accepted sample word and queues the result word it
// implies. The monitor then matches each result word, field by field, against
// the oldest queued one. A short directed run covers:
//   - reading extremes and saturation
//   - zero calibration
//   - calibrate and store
//   - latching from main and calibrating out of the latch
// Three random phases follow, each with its own register setting and idling
// mix. One phase has a long receiver hold-off, one pauses the sender until
// everything has drained, and one latches at once and then runs through a
// full flash period, checking both sides of the flash boundary.
// ----------------------------------------------------------------------------
module two_cell_undervoltage_guard_tb;
    import uvg_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 30;
    localparam int END_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic             kind;
        logic [ADC_W-1:0] adc_cell1;
        logic [ADC_W-1:0] adc_pack;
        logic             calibrate_request;
    } sample_word_t;

    typedef struct packed {
        mode_t                   mode;
        logic [MV_W-1:0]         cell1_mv;
        logic signed [MV2_W-1:0] cell2_mv;
        logic                    store_request;
        logic                    flash_request;
        logic [ADC_W-1:0]        calib_cell1;
        logic [ADC_W-1:0]        calib_pack;
    } guard_result_t;

    class guard_scoreboard;
        mode_t            mode;
        logic [ADC_W-1:0] cal_cell1;
        logic [ADC_W-1:0] cal_pack;
        int unsigned      elapsed_ms;
        int unsigned      limit_mv;
        int unsigned      delay_ms;
        int unsigned      mismatches;
        guard_result_t    pending_reports[$];

        function new();
            mode       = MODE_MAIN;
            cal_cell1  = ADC_W'(1023);
            cal_pack   = ADC_W'(1023);
            elapsed_ms = 0;
            limit_mv   = 3300;
            delay_ms   = 3000;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_UV_LIMIT:  limit_mv  = value[LIMIT_W-1:0];
                REG_UV_DELAY:  delay_ms  = value[DELAY_W-1:0];
                REG_CAL_CELL1: cal_cell1 = value[ADC_W-1:0];
                REG_CAL_PACK:  cal_pack  = value[ADC_W-1:0];
                default:       ;
            endcase
        endfunction

        function int unsigned to_mv(logic [ADC_W-1:0] raw, logic [FULL_W-1:0] full,
                                    logic [ADC_W-1:0] cal);
            int unsigned product;
            if (cal == 0)
            begin
                return 0;
            end
            product = int'(raw) * int'(full);
            return product / int'(cal);
        endfunction

        function void note_sample(sample_word_t s);
            int unsigned   c1;
            int unsigned   pk;
            int            c2;
            logic          low;
            guard_result_t r;
            r = '0;
            if (s.kind)
            begin
                if (elapsed_ms < ELAPSED_MAX)
                begin
                    elapsed_ms++;
                end
            end
            else
            begin
                if (s.calibrate_request)
                begin
                    mode = MODE_CALIB;
                end
                case (mode)
                    MODE_MAIN:
                    begin
                        c1  = to_mv(s.adc_cell1, CELL1_FULL_MV, cal_cell1);
                        pk  = to_mv(s.adc_pack, PACK_FULL_MV, cal_pack);
                        c2  = int'(pk) - int'(c1);
                        low = (c1 < limit_mv) || (c2 < int'(limit_mv));
                        if (low)
                        begin
                            if (elapsed_ms >= delay_ms)
                            begin
                                mode       = MODE_UNDER;
                                elapsed_ms = 0;
                            end
                        end
                        else
                        begin
                            elapsed_ms = 0;
                        end
                        r.cell1_mv = (c1 > MV_SAT) ? MV_SAT : c1[MV_W-1:0];
                        if (c2 > int'(MV_SAT))
                        begin
                            c2 = int'(MV_SAT);
                        end
                        else if (c2 < -int'(MV_SAT))
                        begin
                            c2 = -int'(MV_SAT);
                        end
                        r.cell2_mv = c2[MV2_W-1:0];
                    end
                    MODE_STORE:
                    begin
                        r.store_request = 1'b1;
                        mode            = MODE_MAIN;
                    end
                    MODE_CALIB:
                    begin
                        cal_cell1 = s.adc_cell1;
                        cal_pack  = s.adc_pack;
                        mode      = MODE_STORE;
                    end
                    default:
                    begin
                        if (elapsed_ms >= FLASH_PERIOD_MS)
                        begin
                            elapsed_ms      = 0;
                            r.flash_request = 1'b1;
                        end
                    end
                endcase
            end
            r.mode        = mode;
            r.calib_cell1 = cal_cell1;
            r.calib_pack  = cal_pack;
            pending_reports.push_back(r);
        endfunction

        function void check_result(guard_result_t got);
            guard_result_t want;
            if (pending_reports.size() == 0)
            begin
                $error("result word with nothing expected, mode %0d", got.mode);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.mode !== want.mode)
            begin
                $error("mode expected %0d got %0d", want.mode, got.mode);
                mismatches++;
            end
            if (got.cell1_mv !== want.cell1_mv)
            begin
                $error("cell1_mv expected %0d got %0d", want.cell1_mv, got.cell1_mv);
                mismatches++;
            end
            if (got.cell2_mv !== want.cell2_mv)
            begin
                $error("cell2_mv expected %0d got %0d", want.cell2_mv, got.cell2_mv);
                mismatches++;
            end
            if (got.store_request !== want.store_request)
            begin
                $error("store_request expected %0d got %0d", want.store_request,
                       got.store_request);
                mismatches++;
            end
            if (got.flash_request !== want.flash_request)
            begin
                $error("flash_request expected %0d got %0d", want.flash_request,
                       got.flash_request);
                mismatches++;
            end
            if (got.calib_cell1 !== want.calib_cell1)
            begin
                $error("calib_cell1 expected %0d got %0d", want.calib_cell1,
                       got.calib_cell1);
                mismatches++;
            end
            if (got.calib_pack !== want.calib_pack)
            begin
                $error("calib_pack expected %0d got %0d", want.calib_pack, got.calib_pack);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    uvg_in_if  sample_if();
    uvg_out_if result_if();
    uvg_cfg_if cfg_if();

    two_cell_undervoltage_guard u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    guard_scoreboard board;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    bit              hold_req;
    int unsigned     items_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [ADC_W-1:0] rand_adc();
        return ADC_W'($urandom_range(1023));
    endfunction

    // reading close to the calibration point, so the cell looks healthy
    function automatic logic [ADC_W-1:0] near_full(logic [ADC_W-1:0] cal);
        if (cal == 0)
        begin
            return rand_adc();
        end
        return cal - ADC_W'($urandom_range(int'(cal) / 8));
    endfunction

    function automatic logic [ADC_W-1:0] cal_pick();
        if ($urandom_range(3) == 0)
        begin
            return rand_adc();
        end
        return ADC_W'($urandom_range(900, 1023));
    endfunction

    function automatic sample_word_t step_word(logic [ADC_W-1:0] a1, logic [ADC_W-1:0] ap,
                                               logic req);
        sample_word_t s;
        s.kind              = 1'b0;
        s.adc_cell1         = a1;
        s.adc_pack          = ap;
        s.calibrate_request = req;
        return s;
    endfunction

    function automatic sample_word_t tick_word();
        sample_word_t s;
        s                   = step_word(rand_adc(), rand_adc(), 1'b0);
        s.kind              = 1'b1;
        s.calibrate_request = 1'($urandom_range(1));
        return s;
    endfunction

    function automatic sample_word_t noise_word();
        sample_word_t s;
        s.kind              = 1'($urandom_range(1));
        s.adc_cell1         = rand_adc();
        s.adc_pack          = rand_adc();
        s.calibrate_request = ($urandom_range(5) == 0);
        return s;
    endfunction

    task automatic send_word(sample_word_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_if.valid = 1'b0;
            @(negedge clk);
        end
        sample_if.valid             = 1'b1;
        sample_if.kind              = s.kind;
        sample_if.adc_cell1         = s.adc_cell1;
        sample_if.adc_pack          = s.adc_pack;
        sample_if.calibrate_request = s.calibrate_request;
        do
            @(posedge clk);
        while (!sample_if.ready);
        board.note_sample(s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_if.valid = 1'b0;
        while (board.pending_reports.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.addr  = idx;
        cfg_if.data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_if.ready);
        board.write_reg(idx, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic apply_random_setting();
        int unsigned pick;
        pick = $urandom_range(3);
        if (pick == 0)
        begin
            write_reg(REG_UV_LIMIT, 8400);
        end
        else if (pick == 1)
        begin
            write_reg(REG_UV_LIMIT, $urandom_range(8400));
        end
        else
        begin
            write_reg(REG_UV_LIMIT, $urandom_range(3000, 4300));
        end
        write_reg(REG_UV_DELAY, ($urandom_range(3) == 0) ? 0 : $urandom_range(40));
        write_reg(REG_CAL_CELL1, cal_pick());
        write_reg(REG_CAL_PACK, cal_pick());
    endtask

    task automatic run_mix(int unsigned budget);
        int unsigned stop_at;
        int unsigned r;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(step_word(near_full(board.cal_cell1),
                                        near_full(board.cal_pack), 1'b0));
            end
            else if (r < 55)
            begin
                // low-cell run: ticks then a step that may trip the delay
                repeat ($urandom_range(12)) send_word(tick_word());
                send_word(step_word(rand_adc(), rand_adc(), 1'b0));
            end
            else if (r < 68)
            begin
                send_word(step_word(cal_pick(), cal_pick(), 1'b1));
                send_word(step_word(rand_adc(), rand_adc(), 1'b0));
            end
            else if (r < 82)
            begin
                repeat ($urandom_range(20)) send_word(tick_word());
                send_word(step_word(rand_adc(), rand_adc(), 1'b0));
            end
            else
            begin
                send_word(noise_word());
            end
        end
    endtask

    // latch at once, then one flash period: no flash a tick short, flash on the boundary
    task automatic flash_run();
        write_reg(REG_UV_LIMIT, 8400);
        write_reg(REG_UV_DELAY, 0);
        write_reg(REG_CAL_CELL1, 1023);
        write_reg(REG_CAL_PACK, 1023);
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b1));
        send_word(step_word('0, '0, 1'b0));
        send_word(step_word('0, '0, 1'b0));
        repeat (int'(FLASH_PERIOD_MS) - 1) send_word(tick_word());
        send_word(step_word(rand_adc(), rand_adc(), 1'b0));
        send_word(tick_word());
        send_word(step_word(rand_adc(), rand_adc(), 1'b0));
        send_word(step_word(rand_adc(), rand_adc(), 1'b0));
    endtask

    task automatic directed_run();
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b0));
        send_word(step_word('0, '0, 1'b0));
        send_word(step_word(ADC_W'(1023), '0, 1'b0));
        send_word(step_word('0, ADC_W'(1023), 1'b0));
        send_word(tick_word());
        send_word(tick_word());
        send_word(step_word(ADC_W'(512), ADC_W'(700), 1'b1));
        send_word(step_word(ADC_W'(300), ADC_W'(300), 1'b0));
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b0));
        // calibration of one drives both scalings far past saturation
        send_word(step_word(ADC_W'(1), ADC_W'(1), 1'b1));
        send_word(step_word('0, '0, 1'b0));
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b0));
        write_reg(REG_CAL_PACK, 1023);
        send_word(step_word(ADC_W'(1023), '0, 1'b0));
        write_reg(REG_CAL_CELL1, 0);
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b0));
        write_reg(REG_CAL_PACK, 0);
        send_word(step_word(ADC_W'(700), ADC_W'(800), 1'b0));
        write_reg(REG_CAL_CELL1, 1023);
        write_reg(REG_CAL_PACK, 1023);
        write_reg(REG_UV_LIMIT, 8400);
        write_reg(REG_UV_DELAY, 0);
        send_word(step_word(ADC_W'(1023), ADC_W'(1023), 1'b0));
        send_word(tick_word());
        send_word(step_word(ADC_W'(500), ADC_W'(500), 1'b0));
        send_word(step_word(ADC_W'(1000), ADC_W'(1000), 1'b1));
        send_word(step_word('0, '0, 1'b0));
        send_word(step_word(ADC_W'(1000), ADC_W'(1000), 1'b0));
        write_reg(REG_UV_LIMIT, 0);
        send_word(step_word('0, '0, 1'b0));
    endtask

    initial
    begin : recv_proc
        int unsigned hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_if.ready = 1'b0;
            end
            else
            begin
                result_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_mon
        guard_result_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.mode          = mode_t'(result_if.mode);
            got.cell1_mv      = result_if.cell1_mv;
            got.cell2_mv      = result_if.cell2_mv;
            got.store_request = result_if.store_request;
            got.flash_request = result_if.flash_request;
            got.calib_cell1   = result_if.calib_cell1;
            got.calib_pack    = result_if.calib_pack;
            board.check_result(got);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("** two_cell_undervoltage_guard: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        board                       = new();
        items_sent                  = 0;
        hold_req                    = 1'b0;
        send_idle_pct               = 16;
        recv_idle_pct               = 59;
        rst_n                       = 1'b0;
        sample_if.valid             = 1'b0;
        sample_if.kind              = 1'b0;
        sample_if.adc_cell1         = '0;
        sample_if.adc_pack          = '0;
        sample_if.calibrate_request = 1'b0;
        cfg_if.valid                = 1'b0;
        cfg_if.addr                 = REG_UV_LIMIT;
        cfg_if.data                 = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_run();

        for (phase = 0; phase < 3; phase++)
        begin
            apply_random_setting();
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 16 : 0;
            if (phase == 0)
            begin
                run_mix(60);
                hold_req = 1'b1;
                run_mix(60);
            end
            else if (phase == 1)
            begin
                run_mix(60);
                drain_results();
                run_mix(60);
            end
            else
            begin
                flash_run();
                apply_random_setting();
                run_mix(40);
            end
        end

        drain_results();
        repeat (END_CYCLES) @(negedge clk);
        if (board.mismatches == 0)
        begin
            $display("** two_cell_undervoltage_guard: PASSED **");
        end
        else
        begin
            $display("** two_cell_undervoltage_guard: FAILED **");
        end
        $finish;
    end

endmodule
